// ===== rtl/tls_pkg.sv =====
// shared types, constants and register codes for the traffic light sequencer
package tls_pkg;

   // fixed field widths
   localparam int TIMEOUT_W = 16;
   localparam int HALF_W    = TIMEOUT_W - 1;
   localparam int FIFTH_W   = 14;
   localparam int TENTH_W   = 13;
   localparam int COUNT_W   = TIMEOUT_W + 1;
   localparam int CSR_INDEX_W = 4;

   // blink sequence length and the index width it needs
   localparam int BLINK_INTERVALS = 7;
   localparam int BLINK_W = $clog2(BLINK_INTERVALS + 1);
   localparam logic [BLINK_W:0] BLINK_COUNT = (BLINK_W + 1)'(BLINK_INTERVALS);
   localparam logic [BLINK_W:0] BLINK_LAST  = (BLINK_W + 1)'(BLINK_INTERVALS - 1);

   // reciprocal of five scaled by 2^18, exact for any 16 bit value
   localparam logic [TIMEOUT_W-1:0] RECIP_FIVE = 16'hCCCD;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_STOP_MODE    = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_TIMEOUT = CSR_INDEX_W'(1);

   // reset values
   localparam int RESET_TIMEOUT_INT = 1500;
   localparam logic [TIMEOUT_W-1:0] RESET_TIMEOUT = TIMEOUT_W'(RESET_TIMEOUT_INT);
   localparam logic [HALF_W-1:0]  RESET_HALF  = HALF_W'(RESET_TIMEOUT_INT / 2);
   localparam logic [FIFTH_W-1:0] RESET_FIFTH = FIFTH_W'(RESET_TIMEOUT_INT / 5);
   localparam logic [TENTH_W-1:0] RESET_TENTH = TENTH_W'(RESET_TIMEOUT_INT / 10);

   // phase codes as reported in phase_code
   typedef enum logic [2:0] {
      PH_GREEN       = 3'd0,
      PH_BLINK       = 3'd1,
      PH_YELLOW_PRE  = 3'd2,
      PH_RED         = 3'd3,
      PH_RED_HOLD    = 3'd4,
      PH_YELLOW_POST = 3'd5
   } phase_type;

   // configuration with the phase lengths derived from the base time
   typedef struct packed {
      logic                 stop_mode;
      logic [TIMEOUT_W-1:0] t;
      logic [HALF_W-1:0]    t_half;
      logic [FIFTH_W-1:0]   t_fifth;
      logic [TENTH_W-1:0]   t_tenth;
   } cfg_type;

endpackage

// ===== rtl/tls_csr.sv =====
// configuration registers and the phase lengths derived from the base time
module tls_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [tls_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tls_pkg::TIMEOUT_W-1:0]      csr_data,
   output tls_pkg::cfg_type                   cfg
);

   logic                              stop_ff, stop_in;
   logic [tls_pkg::TIMEOUT_W-1:0]     t_ff, t_in;
   logic [tls_pkg::HALF_W-1:0]        half_ff, half_in;
   logic [tls_pkg::FIFTH_W-1:0]       fifth_ff, fifth_in;
   logic [tls_pkg::TENTH_W-1:0]       tenth_ff, tenth_in;
   logic [2*tls_pkg::TIMEOUT_W-1:0]   recip_prod;

   assign csr_ready = 1'b1;

   // x/5 and x/10 through one multiply by the scaled reciprocal
   assign recip_prod = (2*tls_pkg::TIMEOUT_W)'(csr_data) *
                       (2*tls_pkg::TIMEOUT_W)'(tls_pkg::RECIP_FIVE);

   // register writes
   always_comb begin
      stop_in  = stop_ff;
      t_in     = t_ff;
      half_in  = half_ff;
      fifth_in = fifth_ff;
      tenth_in = tenth_ff;
      if (csr_valid) begin
         case (csr_index)
            tls_pkg::CSR_STOP_MODE: begin
               stop_in = csr_data[0];
            end
            tls_pkg::CSR_BASE_TIMEOUT: begin
               t_in     = csr_data;
               half_in  = csr_data[tls_pkg::TIMEOUT_W-1:1];
               fifth_in = recip_prod[2*tls_pkg::TIMEOUT_W-1:18];
               tenth_in = recip_prod[2*tls_pkg::TIMEOUT_W-1:19];
            end
            default: begin
               stop_in = stop_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_ff  <= 1'b1;
         t_ff     <= tls_pkg::RESET_TIMEOUT;
         half_ff  <= tls_pkg::RESET_HALF;
         fifth_ff <= tls_pkg::RESET_FIFTH;
         tenth_ff <= tls_pkg::RESET_TENTH;
      end else begin
         stop_ff  <= stop_in;
         t_ff     <= t_in;
         half_ff  <= half_in;
         fifth_ff <= fifth_in;
         tenth_ff <= tenth_in;
      end
   end

   assign cfg.stop_mode = stop_ff;
   assign cfg.t         = t_ff;
   assign cfg.t_half    = half_ff;
   assign cfg.t_fifth   = fifth_ff;
   assign cfg.t_tenth   = tenth_ff;

endmodule

// ===== rtl/tls_core.sv =====
// phase state, one-tick phase resolution and the result register
module tls_core (
   input  logic              clock,
   input  logic              reset,
   input  tls_pkg::cfg_type  cfg,
   input  logic              in_valid,
   input  logic              in_button,
   output logic              in_ready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [23:0]       rsp_tdata
);

   typedef struct packed {
      tls_pkg::phase_type                phase;
      logic [tls_pkg::COUNT_W-1:0]       tc;
      logic [tls_pkg::BLINK_W-1:0]       bi;
      logic                              gl;
   } st_type;

   tls_pkg::phase_type                phase_ff;
   logic [tls_pkg::COUNT_W-1:0]       tc_ff;
   logic [tls_pkg::BLINK_W-1:0]       bi_ff;
   logic                              gl_ff;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [23:0]                       rsp_data_ff;

   st_type                            cur, s1, s2, s3, s4, s5, s6, s7, s8, nxt;
   logic [tls_pkg::COUNT_W-1:0]       hold;
   logic [23:0]                       rsp_data_in;
   logic                              take;

   // red: ends on zero time left or on a press in stop mode
   function automatic st_type step_red(st_type s, tls_pkg::cfg_type c, logic pr);
      st_type r;
      r = s;
      if (s.phase == tls_pkg::PH_RED && (s.tc == '0 || (c.stop_mode && pr))) begin
         if (c.stop_mode && s.tc > {1'b0, c.t}) begin
            r.phase = tls_pkg::PH_RED_HOLD;
            r.tc    = s.tc - {1'b0, c.t};
         end else begin
            r.phase = tls_pkg::PH_YELLOW_POST;
            r.tc    = '0;
         end
      end
      return r;
   endfunction

   // red hold: ends when the count runs out
   function automatic st_type step_hold(st_type s);
      st_type r;
      r = s;
      if (s.phase == tls_pkg::PH_RED_HOLD && s.tc == '0) begin
         r.phase = tls_pkg::PH_YELLOW_POST;
         r.tc    = '0;
      end
      return r;
   endfunction

   // yellow after red: back to green, toggling the green level
   function automatic st_type step_ypost(st_type s, tls_pkg::cfg_type c);
      st_type r;
      r = s;
      if (s.phase == tls_pkg::PH_YELLOW_POST && s.tc >= tls_pkg::COUNT_W'(c.t_fifth)) begin
         r.phase = tls_pkg::PH_GREEN;
         r.tc    = '0;
         r.gl    = ~s.gl;
      end
      return r;
   endfunction

   // green: into blinking, toggling the green level
   function automatic st_type step_green(st_type s, tls_pkg::cfg_type c);
      st_type r;
      r = s;
      if (s.phase == tls_pkg::PH_GREEN && s.tc >= tls_pkg::COUNT_W'(c.t_half)) begin
         r.phase = tls_pkg::PH_BLINK;
         r.tc    = '0;
         r.bi    = '0;
         r.gl    = ~s.gl;
      end
      return r;
   endfunction

   // blinking: one interval ahead, or all remaining ones when intervals are empty
   function automatic st_type step_blink(st_type s, tls_pkg::cfg_type c);
      st_type r;
      logic [tls_pkg::BLINK_W:0] bi_ext;
      logic [tls_pkg::BLINK_W:0] bi_nxt;
      logic [tls_pkg::BLINK_W:0] left;
      r      = s;
      bi_ext = {1'b0, s.bi};
      bi_nxt = bi_ext + 1'b1;
      left   = tls_pkg::BLINK_LAST - bi_ext;
      if (s.phase == tls_pkg::PH_BLINK &&
          !(bi_ext < tls_pkg::BLINK_COUNT && s.tc < tls_pkg::COUNT_W'(c.t_tenth))) begin
         if (c.t_tenth == '0) begin
            // every remaining interval toggles once, so only the parity counts
            r.phase = tls_pkg::PH_YELLOW_PRE;
            r.tc    = '0;
            r.bi    = '0;
            if (bi_ext < tls_pkg::BLINK_LAST) begin
               r.gl = s.gl ^ left[0];
            end
         end else if (bi_nxt < tls_pkg::BLINK_COUNT) begin
            r.bi = bi_nxt[tls_pkg::BLINK_W-1:0];
            r.tc = '0;
            r.gl = ~s.gl;
         end else begin
            r.phase = tls_pkg::PH_YELLOW_PRE;
            r.tc    = '0;
            r.bi    = '0;
         end
      end
      return r;
   endfunction

   // yellow before red: red loads twice the base time
   function automatic st_type step_ypre(st_type s, tls_pkg::cfg_type c);
      st_type r;
      r = s;
      if (s.phase == tls_pkg::PH_YELLOW_PRE && s.tc >= tls_pkg::COUNT_W'(c.t_fifth)) begin
         r.phase = tls_pkg::PH_RED;
         r.tc    = {c.t, 1'b0};
      end
      return r;
   endfunction

   assign take       = in_valid && in_ready;
   assign in_ready   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // resolve finished phases in cycle order, at most once around plus red and red hold again
   always_comb begin
      cur.phase = phase_ff;
      cur.tc    = tc_ff;
      cur.bi    = bi_ff;
      cur.gl    = gl_ff;
      s1 = step_red(cur, cfg, in_button);
      s2 = step_hold(s1);
      s3 = step_ypost(s2, cfg);
      s4 = step_green(s3, cfg);
      s5 = step_blink(s4, cfg);
      s6 = step_ypre(s5, cfg);
      s7 = step_red(s6, cfg, in_button);
      s8 = step_hold(s7);
   end

   // count for this tick; a zero base time forces red
   always_comb begin
      nxt  = s8;
      hold = '0;
      if (cfg.t == '0) begin
         nxt.phase = tls_pkg::PH_RED;
         nxt.tc    = '0;
         nxt.bi    = '0;
         nxt.gl    = gl_ff;
      end else begin
         case (s8.phase)
            tls_pkg::PH_RED: begin
               nxt.tc = s8.tc - 1'b1;
            end
            tls_pkg::PH_RED_HOLD: begin
               hold   = s8.tc;
               nxt.tc = s8.tc - 1'b1;
            end
            default: begin
               nxt.tc = s8.tc + 1'b1;
            end
         endcase
      end
   end

   // result item: lamps, phase code and hold count
   always_comb begin
      rsp_data_in[0]    = nxt.gl;
      rsp_data_in[1]    = (nxt.phase == tls_pkg::PH_YELLOW_PRE) ||
                          (nxt.phase == tls_pkg::PH_YELLOW_POST);
      rsp_data_in[2]    = (nxt.phase == tls_pkg::PH_RED) ||
                          (nxt.phase == tls_pkg::PH_RED_HOLD);
      rsp_data_in[5:3]  = nxt.phase;
      rsp_data_in[22:6] = hold;
      rsp_data_in[23]   = 1'b0;
      rsp_valid_in      = take || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= tls_pkg::PH_GREEN;
         tc_ff        <= '0;
         bi_ff        <= '0;
         gl_ff        <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            phase_ff <= nxt.phase;
            tc_ff    <= nxt.tc;
            bi_ff    <= nxt.bi;
            gl_ff    <= nxt.gl;
         end
      end
      if (take) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

`ifndef SYNTHESIS
   // a zero base time reports red
   a_zero_red: assert property (@(posedge clock) disable iff (reset)
      take && cfg.t == '0 |=> rsp_data_ff[5:3] == tls_pkg::PH_RED)
      else $error("zero base time did not report red");

   // hold count only shows in the red hold phase
   a_hold_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[22:6] != '0 |-> rsp_data_ff[5:3] == tls_pkg::PH_RED_HOLD)
      else $error("hold count outside red hold");

   // yellow and red never lit together
   a_lamps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot0(rsp_data_ff[2:1]))
      else $error("yellow and red lit together");

   // blink index stays within the interval count
   a_blink_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, bi_ff} < tls_pkg::BLINK_COUNT)
      else $error("blink index out of range");
`endif

endmodule

// ===== rtl/traffic_light_sequencer.sv =====
// traffic light sequencer top level: input register, configuration and phase core
// a result is offered from the core's result register after its tick item has passed the input register
// throughput: one tick item per cycle while the result is not stalled, set by the single-pass phase resolution
// while a result waits the input register takes one more item, then stalls the input
// reset: green phase with the lamp lit, stop mode on, base time 1500 ticks
// reset clears all control state at once; no clearing pass is needed
module traffic_light_sequencer (
   input  logic                             clock,
   input  logic                             reset,
   // req_tdata: [0] button_pressed
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,
   // rsp_tdata: [0] green_lamp, [1] yellow_lamp, [2] red_lamp, [5:3] phase_code,
   // [22:6] hold_left
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [23:0]                      rsp_tdata,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tls_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [tls_pkg::TIMEOUT_W-1:0]    csr_data
);

   tls_pkg::cfg_type cfg;
   logic             in_valid_ff, in_valid_in;
   logic             in_button_ff;
   logic             core_ready;

   // input register takes an item whenever it is empty or moving on
   assign req_tready  = !in_valid_ff || core_ready;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !core_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_tvalid && req_tready) begin
         in_button_ff <= req_tdata[0];
      end
   end

   tls_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   tls_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .in_valid   (in_valid_ff),
      .in_button  (in_button_ff),
      .in_ready   (core_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
